[sv/jfp_pkg.sv]
// Shared types, constants and the axis mapping table of the joint feedback frame parser.
package jfp_pkg;

	// Frame layout.
	localparam int AXIS_COUNT  = 6;
	localparam int AXIS_W      = 3;
	localparam int COUNT_W     = 14;
	localparam int POS_W       = 5;
	localparam int FRAME_LEN   = 27;
	localparam int DIGIT_FIRST = 1;
	localparam int DIGIT_LAST  = 24;
	localparam int POS_SAT     = 28;

	// ASCII characters the parser looks for.
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Frame queue between the parser and the mapping side.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// Widths of the mapping datapath.
	localparam int N_W         = 36;
	localparam int M_W         = 36;
	localparam int P_W         = 22;
	localparam int R_W         = 21;
	localparam int D_W         = 18;
	localparam int QE_W        = 18;
	localparam int T_W         = QE_W + D_W + 1;
	localparam int SHIFT_SHORT = 26;
	localparam int SHIFT_LONG  = 37;

	typedef logic signed [15:0] angle_t;
	localparam angle_t ANGLE_MAX = 16'sh7FFF;
	localparam angle_t ANGLE_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_LENGTH = 2'd1,
		ST_BAD_DIGIT  = 2'd2,
		ST_ZERO_FRAME = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ISSUE,
		BK_DRAIN,
		BK_HOLD
	} back_state_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		status_t status;
		angle_t  joint1_angle;
		angle_t  joint2_angle;
		angle_t  joint3_angle;
		angle_t  joint4_angle;
		angle_t  joint5_angle;
		angle_t  joint6_angle;
	} out_word_t;

	typedef logic [AXIS_COUNT-1:0][COUNT_W-1:0] counts_t;

	// One finished frame as handed from the parser to the mapping side.
	typedef struct packed {
		status_t status;
		counts_t counts;
	} job_t;

	typedef struct packed {
		logic               valid;
		logic [AXIS_W-1:0]  axis;
		logic [COUNT_W-1:0] count;
	} map_req_t;

	typedef struct packed {
		logic              valid;
		logic [AXIS_W-1:0] axis;
		angle_t            angle;
	} map_rsp_t;

	// Each axis maps as round(N / d) with N = p * count + q, rounded half away
	// from zero. The quotient by 2d uses the reciprocal r and a right shift.
	typedef struct packed {
		logic signed [P_W-1:0] p;
		logic signed [N_W-1:0] q;
		logic [D_W-1:0]        d;
		logic [R_W-1:0]        r;
		logic                  long_shift;
	} coef_t;

	function automatic coef_t axis_coef(input logic [AXIS_W-1:0] axis);
		coef_t c;
		c = '0;
		unique case (axis)
			3'd0: begin
				c.p = -22'sd157;
				c.q = 36'sd321536;
				c.d = 18'd25;
				c.r = 21'd1342177;
				c.long_shift = 1'b0;
			end
			3'd1, 3'd2: begin
				c.p = 22'sd157;
				c.q = -36'sd160768;
				c.d = 18'd25;
				c.r = 21'd1342177;
				c.long_shift = 1'b0;
			end
			3'd3: begin
				c.p = -22'sd1286144;
				c.q = 36'sd6430076928;
				c.d = 18'd249975;
				c.r = 21'd274905;
				c.long_shift = 1'b1;
			end
			3'd4: begin
				c.p = 22'sd321536;
				c.q = -36'sd1607519232;
				c.d = 18'd249975;
				c.r = 21'd274905;
				c.long_shift = 1'b1;
			end
			default: begin
				c.p = 22'sd1286144;
				c.q = -36'sd6430076928;
				c.d = 18'd249975;
				c.r = 21'd274905;
				c.long_shift = 1'b1;
			end
		endcase
		return c;
	endfunction

endpackage

[sv/jfp_front.sv]
// Byte parser: tracks the frame position, checks digits and collects the six counts.
module jfp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jfp_pkg::in_word_t rx_word,
	input  logic            q_full,
	output logic            job_push,
	output jfp_pkg::job_t   job
);
	import jfp_pkg::*;

	logic [POS_W-1:0]   pos_q;
	logic               bad_q;
	logic               zero_q;
	logic [COUNT_W-1:0] acc_q;
	counts_t            counts_q;

	logic               take;
	logic [7:0]         b;
	logic               is_digit;
	logic [3:0]         digit_val;
	logic               in_digits;
	logic               group_end;
	logic [COUNT_W-1:0] acc_next;
	logic               bad_next;
	logic               zero_next;
	logic [POS_W-1:0]   pos_m1;
	logic [AXIS_W-1:0]  slot;
	status_t            status;

	// Classify the incoming byte and work out the next frame state.
	always_comb begin
		take      = push && !q_full;
		b         = rx_word.rx_byte;
		is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
		digit_val = is_digit ? 4'(b - CH_ZERO) : 4'd0;
		in_digits = (pos_q >= POS_W'(DIGIT_FIRST)) && (pos_q <= POS_W'(DIGIT_LAST));
		group_end = in_digits && (pos_q[1:0] == 2'b00);
		acc_next  = COUNT_W'({acc_q, 3'b000}) + COUNT_W'({acc_q, 1'b0})
			+ COUNT_W'(digit_val);
		bad_next  = bad_q || (in_digits && !is_digit);
		zero_next = zero_q
			&& !((pos_q == '0) && (b != CH_S))
			&& !(in_digits && (b != CH_ZERO));
		pos_m1    = pos_q - POS_W'(1);
		slot      = AXIS_W'(pos_m1 >> 2);
	end

	// Status priority: length, then digits, then the all-zero frame.
	always_comb begin
		priority if (pos_q != POS_W'(FRAME_LEN - 1)) begin
			status = ST_BAD_LENGTH;
		end else if (bad_next) begin
			status = ST_BAD_DIGIT;
		end else if (zero_next) begin
			status = ST_ZERO_FRAME;
		end else begin
			status = ST_OK;
		end
	end

	assign job_push   = take && rx_word.end_of_message;
	assign job.status = status;
	assign job.counts = counts_q;

	// Frame state; it returns to its reset value after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			bad_q  <= 1'b0;
			zero_q <= 1'b1;
			acc_q  <= '0;
		end else if (take) begin
			if (rx_word.end_of_message) begin
				pos_q  <= '0;
				bad_q  <= 1'b0;
				zero_q <= 1'b1;
				acc_q  <= '0;
			end else begin
				pos_q  <= (pos_q < POS_W'(POS_SAT)) ? pos_q + POS_W'(1) : POS_W'(POS_SAT);
				bad_q  <= bad_next;
				zero_q <= zero_next;
				if (in_digits) begin
					acc_q <= group_end ? '0 : acc_next;
				end
			end
		end
	end

	// The fourth digit of a group closes that axis count.
	always_ff @(posedge clk) begin
		if (take && group_end) begin
			counts_q[slot] <= acc_next;
		end
	end

endmodule

[sv/jfp_queue.sv]
// Short queue of finished frames between the parser and the mapping side.
module jfp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jfp_pkg::job_t wr_job,
	output logic          full,
	output logic          valid,
	output jfp_pkg::job_t head,
	input  logic          pop
);
	import jfp_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

[sv/jfp_mapper.sv]
// Five-stage pipeline that maps one axis count to a saturated Q4.12 angle per cycle.
module jfp_mapper (
	input  logic              clk,
	input  logic              arst_n,
	input  jfp_pkg::map_req_t req,
	output jfp_pkg::map_rsp_t rsp
);
	import jfp_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [AXIS_W-1:0] axis_s1, axis_s2, axis_s3, axis_s4, axis_s5;

	logic signed [N_W-1:0] n_s1;
	logic [M_W-1:0]        m_s2, m_s3, m_s4;
	logic                  neg_s2, neg_s3, neg_s4;
	logic [QE_W-1:0]       qe_s3, qe_s4;
	logic [T_W-1:0]        t_s4;
	angle_t                angle_s5;

	coef_t                 coef1, coef2, coef3, coef4, coef5;
	logic signed [N_W-1:0] prod1;
	logic signed [N_W-1:0] n1;
	logic [M_W-1:0]        mag2;
	logic [M_W-1:0]        m2;
	logic [M_W+R_W-1:0]    prod3;
	logic [QE_W-1:0]       qe3;
	logic [T_W-1:0]        t4;
	logic [T_W-1:0]        r5;
	logic                  bump5;
	logic [QE_W:0]         q5;
	angle_t                angle5;

	// Stage 1: numerator as a linear function of the count.
	always_comb begin
		coef1 = axis_coef(req.axis);
		prod1 = coef1.p * $signed({1'b0, req.count});
		n1    = prod1 + coef1.q;
	end

	// Stage 2: twice the magnitude plus the divisor, for rounding half away from zero.
	always_comb begin
		coef2 = axis_coef(axis_s1);
		mag2  = n_s1[N_W-1] ? M_W'(-n_s1) : M_W'(n_s1);
		m2    = {mag2[M_W-2:0], 1'b0} + M_W'(coef2.d);
	end

	// Stage 3: quotient estimate by reciprocal, at most one below the true value.
	always_comb begin
		coef3 = axis_coef(axis_s2);
		prod3 = m_s2 * coef3.r;
		qe3   = coef3.long_shift ? QE_W'(prod3 >> SHIFT_LONG) : QE_W'(prod3 >> SHIFT_SHORT);
	end

	// Stage 4: product of the estimate and the divisor.
	always_comb begin
		coef4 = axis_coef(axis_s3);
		t4    = qe_s3 * {coef4.d, 1'b0};
	end

	// Stage 5: correct the estimate, restore the sign and saturate.
	always_comb begin
		coef5 = axis_coef(axis_s4);
		r5    = T_W'(m_s4) - t_s4;
		bump5 = (r5 >= T_W'({coef5.d, 1'b0}));
		q5    = {1'b0, qe_s4} + (QE_W + 1)'(bump5);
		if (neg_s4) begin
			angle5 = (q5 >= (QE_W + 1)'(32768)) ? ANGLE_MIN : angle_t'(~q5[15:0] + 16'd1);
		end else begin
			angle5 = (q5 > (QE_W + 1)'(32767)) ? ANGLE_MAX : angle_t'(q5[15:0]);
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage data.
	always_ff @(posedge clk) begin
		axis_s1  <= req.axis;
		n_s1     <= n1;
		axis_s2  <= axis_s1;
		m_s2     <= m2;
		neg_s2   <= n_s1[N_W-1];
		axis_s3  <= axis_s2;
		m_s3     <= m_s2;
		neg_s3   <= neg_s2;
		qe_s3    <= qe3;
		axis_s4  <= axis_s3;
		m_s4     <= m_s3;
		neg_s4   <= neg_s3;
		qe_s4    <= qe_s3;
		t_s4     <= t4;
		axis_s5  <= axis_s4;
		angle_s5 <= angle5;
	end

	assign rsp.valid = v_s5;
	assign rsp.axis  = axis_s5;
	assign rsp.angle = angle_s5;

endmodule

[sv/jfp_back.sv]
// Result side: takes queued frames, maps the six axes of good ones and holds the output word.
module jfp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  jfp_pkg::job_t      head,
	output logic               job_pop,
	output jfp_pkg::out_word_t result,
	output logic               empty,
	input  logic               pop
);
	import jfp_pkg::*;

	localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXIS_COUNT - 1);

	back_state_t       state_q, state_d;
	logic [AXIS_W-1:0] issue_q;
	logic              out_valid_q;
	out_word_t         out_q;
	angle_t            angles_q [AXIS_COUNT];

	logic     out_free;
	logic     issue;
	logic     load_reject;
	logic     load_mapped;
	logic     last_done;
	map_req_t req;
	map_rsp_t rsp;

	jfp_mapper u_mapper (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign out_free  = !out_valid_q || pop;
	assign last_done = rsp.valid && (rsp.axis == AXIS_LAST);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid && (head.status == ST_OK)) begin
					state_d = BK_ISSUE;
				end
			end
			BK_ISSUE: begin
				if (issue_q == AXIS_LAST) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (last_done) begin
					state_d = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		issue       = 1'b0;
		load_reject = 1'b0;
		load_mapped = 1'b0;
		unique case (state_q)
			BK_IDLE:  load_reject = job_valid && (head.status != ST_OK) && out_free;
			BK_ISSUE: issue = 1'b1;
			BK_DRAIN: ;
			BK_HOLD:  load_mapped = out_free;
			default:  ;
		endcase
		job_pop = load_reject || load_mapped;
	end

	assign req.valid = issue;
	assign req.axis  = issue_q;
	assign req.count = head.counts[issue_q];

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			issue_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (issue) begin
				issue_q <= (issue_q == AXIS_LAST) ? '0 : issue_q + AXIS_W'(1);
			end
			if (load_reject || load_mapped) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Collect mapped angles and load the output word.
	always_ff @(posedge clk) begin
		if (rsp.valid) begin
			angles_q[rsp.axis] <= rsp.angle;
		end
		if (load_reject) begin
			out_q.status       <= head.status;
			out_q.joint1_angle <= '0;
			out_q.joint2_angle <= '0;
			out_q.joint3_angle <= '0;
			out_q.joint4_angle <= '0;
			out_q.joint5_angle <= '0;
			out_q.joint6_angle <= '0;
		end else if (load_mapped) begin
			out_q.status       <= ST_OK;
			out_q.joint1_angle <= angles_q[0];
			out_q.joint2_angle <= angles_q[1];
			out_q.joint3_angle <= angles_q[2];
			out_q.joint4_angle <= angles_q[3];
			out_q.joint5_angle <= angles_q[4];
			out_q.joint6_angle <= angles_q[5];
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

endmodule

[sv/joint_feedback_frame_parser.sv]
// Top level of the joint feedback frame parser: parser, frame queue and result side.
//
// Frames of encoder feedback come in one byte word per clock and leave as one
// result word per frame, taken on the byte flagged as last. The parser takes a
// byte every cycle as long as its four-entry frame queue has room; full is the
// queue's full flag and holds off all bytes while it is set. A rejected frame
// (wrong length, non-digit, all-zero frame) skips the mapper; its word is loaded
// into the output word register from the queue head once that register is free.
// A good frame runs its six axes through a shared five-stage mapping pipeline,
// one axis per cycle; since a good frame is 27 bytes long, the result side keeps
// up with a continuous byte stream. The output word register lets the parser keep
// working while a result waits to be popped.
module joint_feedback_frame_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  jfp_pkg::in_word_t  rx_word,
	output logic               empty,
	input  logic               pop,
	output jfp_pkg::out_word_t result
);
	import jfp_pkg::*;

	logic q_full;
	logic job_push;
	job_t job;
	logic job_valid;
	job_t head;
	logic job_pop;

	jfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rx_word  (rx_word),
		.q_full   (q_full),
		.job_push (job_push),
		.job      (job)
	);

	jfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wr_job (job),
		.full   (q_full),
		.valid  (job_valid),
		.head   (head),
		.pop    (job_pop)
	);

	jfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.head      (head),
		.job_pop   (job_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	assign full = q_full;

endmodule

[tb/sv/joint_feedback_frame_parser_test.sv]
// Self-checking testbench for the joint feedback frame parser: directed frames, then random frames.
module joint_feedback_frame_parser_test;
	import jfp_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_WORDS = 600;
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_WAIT  = 40;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_word_t  rx_word = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_word_t result;

	// A directed frame, and its result word where it is obvious.
	typedef struct {
		string     text;
		bit        known;
		out_word_t want;
	} frame_case_t;

	frame_case_t directed_frames [] = '{
		'{"S000000000000000000000000\r\n", 1'b1, '{ST_ZERO_FRAME, 0, 0, 0, 0, 0, 0}},
		'{"A000000000000000000000000\r\n", 1'b1,
			'{ST_OK, 12861, -6431, -6431, 25723, -6431, -25723}},
		'{"S999999999999999999999999\r\n", 1'b1,
			'{ST_OK, -32768, 32767, 32767, -25723, 6431, 25723}},
		'{"S000000000000000000000001\r\n", 1'b0, '0},
		'{"S204807681024500050005000\r\n", 1'b0, '0},
		'{"S409615360512000099990000\r\n", 1'b0, '0},
		'{"s000000000000000000000000\377\377", 1'b0, '0},
		'{"S000000000000000000000000ZZ", 1'b1, '{ST_ZERO_FRAME, 0, 0, 0, 0, 0, 0}},
		'{"\n", 1'b1, '{ST_BAD_LENGTH, 0, 0, 0, 0, 0, 0}},
		'{"S1234\r\n", 1'b1, '{ST_BAD_LENGTH, 0, 0, 0, 0, 0, 0}},
		'{"S00000000000000000000000\r\n", 1'b1, '{ST_BAD_LENGTH, 0, 0, 0, 0, 0, 0}},
		'{"S000000000000000000000000\r\n\n", 1'b1, '{ST_BAD_LENGTH, 0, 0, 0, 0, 0, 0}},
		'{"S000000000000000000000000\r\n0123456789012", 1'b1,
			'{ST_BAD_LENGTH, 0, 0, 0, 0, 0, 0}},
		'{"S0000/0000000000000000000\r\n", 1'b1, '{ST_BAD_DIGIT, 0, 0, 0, 0, 0, 0}},
		'{"S00000000000000000000000:\r\n", 1'b1, '{ST_BAD_DIGIT, 0, 0, 0, 0, 0, 0}},
		'{"S\37700000000000000000000000\r\n", 1'b1, '{ST_BAD_DIGIT, 0, 0, 0, 0, 0, 0}},
		'{"S0000000000 0000000000000\r\n", 1'b1, '{ST_BAD_DIGIT, 0, 0, 0, 0, 0, 0}},
		'{"S12a\r\n", 1'b1, '{ST_BAD_LENGTH, 0, 0, 0, 0, 0, 0}}
	};

	// Linear map of each axis: low count, high count, low angle, high angle (rad / 200).
	longint axis_line [AXIS_COUNT][4] = '{
		'{0, 4096, 628, -628},
		'{0, 1536, -314, 157},
		'{512, 1536, -157, 157},
		'{0, 9999, 1256, -1256},
		'{0, 9999, -314, 314},
		'{0, 9999, -1256, 1256}
	};

	// Frame state of the predictor.
	logic [POS_W-1:0]   frame_pos = '0;
	bit                 digit_fault = 1'b0;
	bit                 zero_lead = 1'b1;
	logic [COUNT_W-1:0] group_value = '0;
	logic [COUNT_W-1:0] axis_count [AXIS_COUNT];

	out_word_t awaited_results [$];
	int        bad_results = 0;
	int        words_sent = 0;
	int        idle_cycles = 0;
	bit        calm = 1'b0;

	string field_name [7] = '{"status", "joint1_angle", "joint2_angle", "joint3_angle",
		"joint4_angle", "joint5_angle", "joint6_angle"};

	joint_feedback_frame_parser uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.rx_word (rx_word),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	always #HALF_PERIOD clk = ~clk;

	// Count to Q4.12 radians, rounded half away from zero and saturated.
	function automatic angle_t axis_angle(input int axis, input logic [COUNT_W-1:0] count);
		longint lo, span, num, den, q;
		lo = axis_line[axis][0];
		span = axis_line[axis][1] - lo;
		num = 4096 * (axis_line[axis][2] * span
			+ (longint'(count) - lo) * (axis_line[axis][3] - axis_line[axis][2]));
		den = 200 * span;
		if (num >= 0) begin
			q = (2 * num + den) / (2 * den);
		end else begin
			q = -((2 * (-num) + den) / (2 * den));
		end
		if (q > 32767) begin
			q = 32767;
		end
		if (q < -32768) begin
			q = -32768;
		end
		return angle_t'(q[15:0]);
	endfunction

	// Advance the predicted parser by one byte word; done is set on the last byte.
	task automatic frame_step(input in_word_t w, output bit done, output out_word_t res);
		logic [7:0] b;
		bit         is_digit;
		b = w.rx_byte;
		done = 1'b0;
		res = '0;
		if (frame_pos == 0) begin
			if (b != CH_S) begin
				zero_lead = 1'b0;
			end
		end else if (frame_pos <= DIGIT_LAST) begin
			is_digit = b >= CH_ZERO && b <= CH_NINE;
			if (!is_digit) begin
				digit_fault = 1'b1;
			end
			if (b != CH_ZERO) begin
				zero_lead = 1'b0;
			end
			group_value = group_value * 14'd10 + (is_digit ? COUNT_W'(b - CH_ZERO) : '0);
			if (frame_pos[1:0] == 2'd0) begin
				axis_count[(int'(frame_pos) - 1) / 4] = group_value;
				group_value = '0;
			end
		end
		if (!w.end_of_message) begin
			if (frame_pos < POS_SAT) begin
				frame_pos = frame_pos + 1'b1;
			end
		end else begin
			done = 1'b1;
			if (frame_pos != FRAME_LEN - 1) begin
				res.status = ST_BAD_LENGTH;
			end else if (digit_fault) begin
				res.status = ST_BAD_DIGIT;
			end else if (zero_lead) begin
				res.status = ST_ZERO_FRAME;
			end else begin
				res.status = ST_OK;
				res.joint1_angle = axis_angle(0, axis_count[0]);
				res.joint2_angle = axis_angle(1, axis_count[1]);
				res.joint3_angle = axis_angle(2, axis_count[2]);
				res.joint4_angle = axis_angle(3, axis_count[3]);
				res.joint5_angle = axis_angle(4, axis_count[4]);
				res.joint6_angle = axis_angle(5, axis_count[5]);
			end
			frame_pos = '0;
			digit_fault = 1'b0;
			zero_lead = 1'b1;
			group_value = '0;
		end
	endtask

	function automatic int word_field(input out_word_t w, input int idx);
		case (idx)
			0: return int'(w.status);
			1: return int'(w.joint1_angle);
			2: return int'(w.joint2_angle);
			3: return int'(w.joint3_angle);
			4: return int'(w.joint4_angle);
			5: return int'(w.joint5_angle);
			default: return int'(w.joint6_angle);
		endcase
	endfunction

	// Offer one byte word until it is taken, then sometimes pause.
	task automatic send_byte(input in_word_t w, output bit done, output out_word_t res);
		push <= 1'b1;
		rx_word <= w;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		frame_step(w, done, res);
		words_sent++;
		if (!calm && $urandom_range(0, 99) < 2) begin
			push <= 1'b0;
			rx_word <= in_word_t'(9'($urandom));
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Send a whole frame, flagging its last byte; a known word overrides the prediction.
	task automatic send_frame(input logic [7:0] body [$], input bit known, input out_word_t want);
		in_word_t  w;
		bit        done;
		out_word_t res;
		for (int i = 0; i < body.size(); i++) begin
			w.rx_byte = body[i];
			w.end_of_message = (i == body.size() - 1);
			send_byte(w, done, res);
			if (done) begin
				awaited_results.push_back(known ? want : res);
			end
		end
	endtask

	// Mostly well-formed frames with random counts; some corrupted, some of wrong length.
	task automatic random_frame();
		logic [7:0] body [$];
		logic [7:0] bad;
		int         kind, len, cnt;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			body.push_back($urandom_range(0, 3) != 0 ? CH_S : 8'($urandom));
			for (int a = 0; a < AXIS_COUNT; a++) begin
				case ($urandom_range(0, 5))
					0: cnt = 0;
					1: cnt = 9999;
					2: cnt = 4096;
					3: cnt = $urandom_range(0, 1536);
					4: cnt = $urandom_range(512, 4096);
					default: cnt = $urandom_range(0, 9999);
				endcase
				if (kind < 8) begin
					cnt = 0;
				end
				for (int k = 1000; k >= 1; k /= 10) begin
					body.push_back(8'(int'(CH_ZERO) + (cnt / k) % 10));
				end
			end
			body.push_back(8'($urandom));
			body.push_back(8'($urandom));
			if (kind >= 72) begin
				do begin
					bad = 8'($urandom);
				end while (bad >= CH_ZERO && bad <= CH_NINE);
				body[$urandom_range(DIGIT_FIRST, DIGIT_LAST)] = bad;
			end
		end else begin
			case ($urandom_range(0, 2))
				0: len = FRAME_LEN - 1;
				1: len = FRAME_LEN + 1;
				default: len = $urandom_range(1, 45);
			endcase
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 3))
					0: body.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
					1: body.push_back(8'(int'(CH_ZERO) + $urandom_range(0, 9)));
					default: body.push_back(8'($urandom));
				endcase
			end
		end
		send_frame(body, 1'b0, '0);
	endtask

	// Result side: check each popped word against the oldest expectation, stall at random.
	always @(posedge clk) begin
		out_word_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					bad_results++;
					$display("%0t: unexpected result word, status %0d", $time, result.status);
				end else begin
					want = awaited_results.pop_front();
					for (int i = 0; i < 7; i++) begin
						if (word_field(want, i) != word_field(result, i)) begin
							bad_results++;
							$display("%0t: %s expected %0d, got %0d", $time, field_name[i],
								word_field(want, i), word_field(result, i));
						end
					end
				end
			end
			pop <= calm || $urandom_range(0, 99) >= 6;
		end
	end

	// Watchdog on cycles in which no word moves on either side.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus: reset, directed frames, random frames, then drain.
	initial begin
		logic [7:0] body [$];
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed_frames[r]) begin
			body = {};
			for (int i = 0; i < directed_frames[r].text.len(); i++) begin
				body.push_back(directed_frames[r].text[i]);
			end
			send_frame(body, directed_frames[r].known, directed_frames[r].want);
		end
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			// A stretch in the middle runs with both sides never idle.
			calm = words_sent >= 200 && words_sent < 450;
			random_frame();
		end
		calm = 1'b0;
		push <= 1'b0;
		while (awaited_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_WAIT) @(posedge clk);
		if (bad_results == 0 && awaited_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
